/* rtl/core/dds_pkg.sv */
package dds_pkg;

    localparam int SAMPLE_RATE      = 48000;
    localparam int SINE_TABLE_DEPTH = 1024;

    localparam int MS_MAX        = 10000;
    localparam int SCALE_MAX     = 100;
    localparam int DUTY_DEFAULT  = 50;
    localparam int PEAK_DEFAULT  = 8000;
    localparam int MS_DEFAULT    = 1000;
    localparam int SCALE_DEFAULT = 100;
    localparam int MS_PER_SEC    = 1000;
    localparam int PERCENT       = 100;

    localparam int CNT_W   = $clog2(SAMPLE_RATE * (MS_MAX / MS_PER_SEC) + 1);
    localparam int ROM_AW  = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int MUL_AW  = 32;
    localparam int MUL_BW  = 23;
    localparam int PROD_W  = MUL_AW + MUL_BW;

    localparam int RECIP_SHIFT = 29;
    localparam int RECIP_100   = ((1 << RECIP_SHIFT) + PERCENT - 1) / PERCENT;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] Q30_HALF    = 64'd1 << 29;

    // series divisors (2n)(2n+1) as reciprocals scaled by 2^64, rounded up
    localparam logic [127:0] SERIES_ONE     = 128'd1 << 64;
    localparam logic [63:0]  SERIES_RECIP_1 = 64'((SERIES_ONE + 128'd5) / 128'd6);
    localparam logic [63:0]  SERIES_RECIP_2 = 64'((SERIES_ONE + 128'd19) / 128'd20);
    localparam logic [63:0]  SERIES_RECIP_3 = 64'((SERIES_ONE + 128'd41) / 128'd42);
    localparam logic [63:0]  SERIES_RECIP_4 = 64'((SERIES_ONE + 128'd71) / 128'd72);
    localparam logic [63:0]  SERIES_RECIP_5 = 64'((SERIES_ONE + 128'd109) / 128'd110);
    localparam logic [63:0]  SERIES_RECIP_6 = 64'((SERIES_ONE + 128'd155) / 128'd156);
    localparam logic [63:0]  SERIES_RECIP_7 = 64'((SERIES_ONE + 128'd209) / 128'd210);
    localparam logic [63:0]  SERIES_RECIP_8 = 64'((SERIES_ONE + 128'd271) / 128'd272);

    typedef enum logic [2:0] {
        REG_WAVE_SHAPE  = 3'd0,
        REG_PHASE_STEP  = 3'd1,
        REG_PEAK_AMP    = 3'd2,
        REG_DUTY        = 3'd3,
        REG_DURATION    = 3'd4,
        REG_OUT_SCALE   = 3'd5,
        REG_BYTE_SWAP   = 3'd6
    } t_cfg_reg;

    typedef enum logic [1:0] {
        WAVE_SINE     = 2'd0,
        WAVE_SQUARE   = 2'd1,
        WAVE_TRIANGLE = 2'd2,
        WAVE_SAWTOOTH = 2'd3
    } t_wave;

    typedef logic [15:0] t_sine_rom [0:SINE_TABLE_DEPTH];

    function automatic logic [63:0] series_recip(input int n);
        logic [63:0] recip;
        unique case (n)
            1:       recip = SERIES_RECIP_1;
            2:       recip = SERIES_RECIP_2;
            3:       recip = SERIES_RECIP_3;
            4:       recip = SERIES_RECIP_4;
            5:       recip = SERIES_RECIP_5;
            6:       recip = SERIES_RECIP_6;
            7:       recip = SERIES_RECIP_7;
            default: recip = SERIES_RECIP_8;
        endcase
        return recip;
    endfunction

    // round(32768*sin(x)), x in q30, by a fixed-point taylor series
    function automatic logic [15:0] sine_q15(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        for (int n = 1; n <= 8; n++) begin
            term = 64'((128'((term * x2) >> 30) * 128'(series_recip(n))) >> 64);
            if (n[0]) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        return 16'(((sum << 15) + Q30_HALF) >> 30);
    endfunction

    function automatic t_sine_rom build_sine_rom();
        t_sine_rom rom;
        for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
            rom[k] = sine_q15((HALF_PI_Q30 * 64'(k)) / SINE_TABLE_DEPTH);
        end
        rom[0]                = 16'd0;
        rom[SINE_TABLE_DEPTH] = 16'h8000;
        return rom;
    endfunction

endpackage

/* rtl/core/dds_sine_rom.sv */
module dds_sine_rom
    import dds_pkg::*;
(
    input  logic              i_clk,
    input  logic [ROM_AW-1:0] i_addr,
    output logic [15:0]       o_data
);

    localparam t_sine_rom SINE_ROM = build_sine_rom();

    logic [15:0] r_data;

    always_ff @(posedge i_clk) begin
        r_data <= SINE_ROM[i_addr];
    end

    assign o_data = r_data;

endmodule

/* rtl/core/dds_waveform_generator.sv */
// Direct digital synthesis sample source. Each request on the slave stream (tdata bit 0 is
// restart, which clears the phase and the sample count first) yields at most one 16-bit
// two's complement sample on the master stream, with tlast on the final sample of the run.
// No sample comes out while phase_step is zero or once the run of
// SAMPLE_RATE*duration_ms/1000 samples is complete; restart begins a new run. A request
// passes through the states RUNX, DONEK, CHECK, WAVE, AMP, SCL and DIV before the sample
// is loaded in the output register from OUT (sine adds ROM, a registered quarter-wave table
// read), because one shared 32x23 multiplier is used six times in sequence: run length,
// count check, phase scaling, amplitude, level and the divide by 100. The next request is
// taken as soon as the sample is loaded, even while it still waits on the master side.
// Configuration writes land immediately and are meant to be made while no request is in flight.
module dds_waveform_generator
    import dds_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] restart, [7:1] zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] sample_word
    output logic        m_axis_tlast,
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RUNX,
        S_DONEK,
        S_CHECK,
        S_WAVE,
        S_ROM,
        S_AMP,
        S_SCL,
        S_DIV,
        S_OUT
    } t_state;

    // configuration
    logic [1:0]  r_wave_shape;
    logic [31:0] r_phase_step;
    logic [14:0] r_peak;
    logic [6:0]  r_duty;
    logic [13:0] r_duration;
    logic [6:0]  r_scale;
    logic        r_byte_swap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave_shape <= WAVE_SINE;
            r_phase_step <= '0;
            r_peak       <= 15'(PEAK_DEFAULT);
            r_duty       <= 7'(DUTY_DEFAULT);
            r_duration   <= 14'(MS_DEFAULT);
            r_scale      <= 7'(SCALE_DEFAULT);
            r_byte_swap  <= 1'b0;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_WAVE_SHAPE: r_wave_shape <= i_cfg_data[1:0];
                REG_PHASE_STEP: r_phase_step <= i_cfg_data;
                REG_PEAK_AMP:   r_peak       <= i_cfg_data[14:0];
                REG_DUTY:       r_duty       <= i_cfg_data[6:0];
                REG_DURATION:   r_duration   <= i_cfg_data[13:0];
                REG_OUT_SCALE:  r_scale      <= i_cfg_data[6:0];
                REG_BYTE_SWAP:  r_byte_swap  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    logic [13:0] ms_sat;
    logic [6:0]  scale_sat;
    logic [6:0]  duty_eff;

    assign ms_sat    = (r_duration > 14'(MS_MAX)) ? 14'(MS_MAX) : r_duration;
    assign scale_sat = (r_scale > 7'(SCALE_MAX)) ? 7'(SCALE_MAX) : r_scale;
    assign duty_eff  = (r_duty == 7'd0 || r_duty >= 7'(PERCENT)) ? 7'(DUTY_DEFAULT) : r_duty;

    // sequencer state
    t_state              r_state;
    logic [31:0]         r_phase;
    logic [CNT_W-1:0]    r_count;
    logic [PROD_W-1:0]   r_prod;
    logic [31:0]         r_run_x;
    logic                r_last;
    logic signed [16:0]  r_val;
    logic                r_neg;
    logic                r_out_valid;
    logic [15:0]         r_out_data;
    logic                r_out_last;

    // shared multiplier operand select
    logic [MUL_AW-1:0] mul_a;
    logic [MUL_BW-1:0] mul_b;
    logic [PROD_W-1:0] mul_p;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_RUNX: begin
                mul_a = MUL_AW'(SAMPLE_RATE);
                mul_b = MUL_BW'(ms_sat);
            end
            S_DONEK: begin
                mul_a = MUL_AW'(r_count);
                mul_b = MUL_BW'(MS_PER_SEC);
            end
            S_CHECK: begin
                if (r_wave_shape == WAVE_SINE) begin
                    mul_a = {2'b00, r_phase[29:0]};
                    mul_b = MUL_BW'(SINE_TABLE_DEPTH);
                end else begin
                    mul_a = r_phase;
                    mul_b = MUL_BW'(PERCENT);
                end
            end
            S_AMP: begin
                mul_a = MUL_AW'(r_val[16] ? 17'(-r_val) : 17'(r_val));
                mul_b = MUL_BW'(r_peak);
            end
            S_SCL: begin
                mul_a = MUL_AW'(r_prod[30:15]);
                mul_b = MUL_BW'(scale_sat);
            end
            S_DIV: begin
                mul_a = MUL_AW'(r_prod[21:0]);
                mul_b = MUL_BW'(RECIP_100);
            end
            default: ;
        endcase
        mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    // run checks against SAMPLE_RATE*ms, no division needed
    logic [32:0] k_done;
    logic [32:0] k_last;

    assign k_done = 33'(r_prod[31:0]) + 33'(MS_PER_SEC);
    assign k_last = 33'(r_prod[31:0]) + 33'(2 * MS_PER_SEC);

    // wave values that need no table
    logic signed [18:0] tri_t;
    logic signed [18:0] wave_direct;
    logic [ROM_AW-1:0]  sine_idx;
    logic [ROM_AW-1:0]  rom_addr;
    logic [15:0]        rom_data;

    assign tri_t    = 19'(r_phase[31:15]);
    assign sine_idx = r_prod[30 +: ROM_AW];
    assign rom_addr = r_phase[30] ? ROM_AW'(SINE_TABLE_DEPTH) - sine_idx : sine_idx;

    always_comb begin
        unique case (t_wave'(r_wave_shape))
            WAVE_SQUARE: begin
                wave_direct = (r_prod[38:0] < {duty_eff, 32'd0}) ? 19'sd32768 : -19'sd32768;
            end
            WAVE_TRIANGLE: begin
                wave_direct = r_phase[31] ? (19'sd98304 - tri_t) : (tri_t - 19'sd32768);
            end
            WAVE_SAWTOOTH: begin
                wave_direct = 19'(r_phase[31:16]) - 19'sd32768;
            end
            default: begin
                wave_direct = '0;
            end
        endcase
    end

    dds_sine_rom u_sine_rom (
        .i_clk  (i_clk),
        .i_addr (rom_addr),
        .o_data (rom_data)
    );

    logic        out_free;
    logic [15:0] q_mag;
    logic [15:0] sample;

    assign out_free = !r_out_valid || m_axis_tready;
    assign q_mag    = r_prod[RECIP_SHIFT +: 16];
    assign sample   = r_neg ? 16'(-q_mag) : q_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        if (s_axis_tdata[0]) begin
                            r_phase <= '0;
                            r_count <= '0;
                        end
                        r_state <= S_RUNX;
                    end
                end
                S_RUNX: begin
                    r_prod  <= mul_p;
                    r_state <= (r_phase_step == 32'd0) ? S_IDLE : S_DONEK;
                end
                S_DONEK: begin
                    r_run_x <= r_prod[31:0];
                    r_prod  <= mul_p;
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    r_last  <= (k_last > 33'(r_run_x));
                    r_prod  <= mul_p;
                    r_state <= (k_done > 33'(r_run_x)) ? S_IDLE : S_WAVE;
                end
                S_WAVE: begin
                    if (r_wave_shape == WAVE_SINE) begin
                        r_state <= S_ROM;
                    end else begin
                        r_val   <= 17'(wave_direct);
                        r_state <= S_AMP;
                    end
                end
                S_ROM: begin
                    r_val   <= r_phase[31] ? -$signed({1'b0, rom_data})
                                           : $signed({1'b0, rom_data});
                    r_state <= S_AMP;
                end
                S_AMP: begin
                    r_neg   <= r_val[16];
                    r_prod  <= mul_p;
                    r_state <= S_SCL;
                end
                S_SCL: begin
                    r_prod  <= mul_p;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_prod  <= mul_p;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_data  <= r_byte_swap ? {sample[7:0], sample[15:8]} : sample;
                        r_out_last  <= r_last;
                        r_count     <= r_count + 1'b1;
                        r_phase     <= r_phase + r_phase_step;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

`ifndef NO_ASSERTIONS
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && out_free) |=> r_count == CNT_W'($past(r_count) + 1'b1))
        else $error("sample count did not advance with an emitted sample");

    a_zero_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUNX && r_phase_step == 32'd0) |=> (r_state == S_IDLE && !$rose(r_out_valid)))
        else $error("request with zero phase step did not return to idle");

    a_load_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_OUT)
        else $error("output register loaded outside the output step");
`endif

endmodule
